// File: sv/life_automaton_generation_step_core_defines.svh
// ----------------------------------------------------------------------------
// life_automaton_generation_step_core_defines
// assertion macros shared by the life automaton core
// ----------------------------------------------------------------------------
`ifndef LIFE_AUTOMATON_GENERATION_STEP_CORE_DEFINES_SVH
`define LIFE_AUTOMATON_GENERATION_STEP_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define LAGS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define LAGS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lags_pkg.sv
// ----------------------------------------------------------------------------
// lags_pkg
// grid sizes, function codes, controller commands and the cell rule
// ----------------------------------------------------------------------------
`default_nettype none

package lags_pkg;

  localparam int GRID_ROWS = 32;
  localparam int GRID_COLS = 32;

  localparam int FUNC_W  = 2;
  localparam int INDEX_W = 5;
  localparam int BITS_W  = 32;

  localparam int ROW_W  = $clog2(GRID_ROWS);
  localparam int IDX_W  = ((ROW_W > INDEX_W) ? ROW_W : INDEX_W) + 1;
  localparam int WIDE_W = (GRID_COLS > BITS_W) ? GRID_COLS : BITS_W;

  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef logic [GRID_COLS-1:0] row_t;
  typedef logic [ROW_W-1:0]     row_idx_t;

  typedef struct packed {
    logic     host_wr;
    logic     host_rd;
    logic     step_start;
    logic     prime;
    logic     run;
    logic     last;
    logic     out_load;
    row_idx_t row;
  } lags_cmd_t;

  typedef struct packed {
    logic out_free;
  } lags_status_t;

  function automatic row_t to_row(input logic [BITS_W-1:0] b);
    logic [WIDE_W-1:0] t;
    t = WIDE_W'(b);
    return t[GRID_COLS-1:0];
  endfunction

  function automatic logic [BITS_W-1:0] from_row(input row_t r);
    logic [WIDE_W-1:0] t;
    t = WIDE_W'(r);
    return t[BITS_W-1:0];
  endfunction

  // b3/s23 over one row, cells past either edge are dead
  function automatic row_t next_row(input row_t up, input row_t mid, input row_t dn);
    logic [GRID_COLS+1:0] u;
    logic [GRID_COLS+1:0] m;
    logic [GRID_COLS+1:0] d;
    logic [3:0]           n;
    row_t                 res;
    u = {1'b0, up, 1'b0};
    m = {1'b0, mid, 1'b0};
    d = {1'b0, dn, 1'b0};
    res = '0;
    for (int x = 0; x < GRID_COLS; x++) begin
      n = 4'(u[x]) + 4'(u[x+1]) + 4'(u[x+2]) + 4'(m[x]) + 4'(m[x+2])
        + 4'(d[x]) + 4'(d[x+1]) + 4'(d[x+2]);
      res[x] = (n == BIRTH_COUNT) || (mid[x] && (n == SURVIVE_COUNT));
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: sv/lags_in_if.sv
// ----------------------------------------------------------------------------
// lags_in_if
// request channel: function code, row index and row cells
// ----------------------------------------------------------------------------
`default_nettype none

interface lags_in_if import lags_pkg::*;;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [INDEX_W-1:0] row_index;
  logic [BITS_W-1:0] row_bits;

  modport source (output valid, output func, output row_index, output row_bits,
                  input ready);
  modport sink (input valid, input func, input row_index, input row_bits,
                output ready);
endinterface

`default_nettype wire

// File: sv/lags_out_if.sv
// ----------------------------------------------------------------------------
// lags_out_if
// response channel: row index and row cells of a read
// ----------------------------------------------------------------------------
`default_nettype none

interface lags_out_if import lags_pkg::*;;
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] out_row_index;
  logic [BITS_W-1:0]  out_row_bits;

  modport source (output valid, output out_row_index, output out_row_bits,
                  input ready);
  modport sink (input valid, input out_row_index, input out_row_bits,
                output ready);
endinterface

`default_nettype wire

// File: sv/lags_ctrl.sv
// ----------------------------------------------------------------------------
// lags_ctrl
// sequencer for row writes, row reads and the generation sweep
// ----------------------------------------------------------------------------
`default_nettype none

module lags_ctrl import lags_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              valid,
  input  wire logic [FUNC_W-1:0] func,
  output logic                   ready,
  output lags_cmd_t              cmd,
  input  wire lags_status_t      status
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PRIME = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;
  localparam logic [1:0] S_RDOUT = 2'd3;

  localparam row_idx_t LAST_ROW = ROW_W'(GRID_ROWS - 1);

  logic [1:0] state;
  logic [1:0] state_next;
  row_idx_t   cnt;
  row_idx_t   cnt_next;

  always_comb begin
    cmd        = '0;
    cmd.row    = cnt;
    ready      = (state == S_IDLE);
    state_next = state;
    cnt_next   = cnt;
    case (state)
      S_IDLE: begin
        if (valid) begin
          case (func)
            FUNC_WRITE: begin
              cmd.host_wr = 1'b1;
            end
            FUNC_STEP: begin
              cmd.step_start = 1'b1;
              state_next     = S_PRIME;
            end
            FUNC_READ: begin
              cmd.host_rd = 1'b1;
              state_next  = S_RDOUT;
            end
            default: ;
          endcase
        end
      end
      S_PRIME: begin
        cmd.prime  = 1'b1;
        cnt_next   = '0;
        state_next = S_RUN;
      end
      S_RUN: begin
        cmd.run  = 1'b1;
        cmd.last = (cnt == LAST_ROW);
        if (cnt == LAST_ROW) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + ROW_W'(1);
        end
      end
      S_RDOUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/lags_dp.sv
// ----------------------------------------------------------------------------
// lags_dp
// grid memory, three-row window, cell rule and result register
// ----------------------------------------------------------------------------
`default_nettype none

module lags_dp import lags_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lags_cmd_t          cmd,
  output lags_status_t            status,
  input  wire logic [INDEX_W-1:0] row_index,
  input  wire logic [BITS_W-1:0]  row_bits,
  lags_out_if.source              rsp
);

  row_t                 mem [GRID_ROWS];
  logic [GRID_ROWS-1:0] vld;

  row_t               rdata_q;
  logic               rvld_q;
  row_t               eff;
  row_t               up;
  row_t               mid;
  row_t               dn;
  row_t               new_row;
  logic [IDX_W-1:0]   idx_ext;
  logic               req_in_range;
  row_idx_t           req_addr;
  logic [ROW_W:0]     ahead;
  logic               ahead_ok;
  logic               rd_en;
  row_idx_t           rd_addr;
  logic               wr_en;
  row_idx_t           wr_addr;
  row_t               wr_data;
  logic [INDEX_W-1:0] rd_idx_q;
  logic               rd_range_q;
  logic               out_valid;
  logic [INDEX_W-1:0] out_idx;
  logic [BITS_W-1:0]  out_bits;

  assign eff          = rvld_q ? rdata_q : '0;
  assign idx_ext      = IDX_W'(row_index);
  assign req_in_range = idx_ext < IDX_W'(GRID_ROWS);
  assign req_addr     = idx_ext[ROW_W-1:0];
  assign ahead        = {1'b0, cmd.row} + (ROW_W+1)'(2);
  assign ahead_ok     = ahead < (ROW_W+1)'(GRID_ROWS);
  assign dn           = cmd.last ? '0 : eff;
  assign new_row      = next_row(up, mid, dn);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd.host_rd) begin
      rd_en   = req_in_range;
      rd_addr = req_addr;
    end else if (cmd.step_start) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end else if (cmd.prime) begin
      rd_en   = 1'b1;
      rd_addr = ROW_W'(1);
    end else if (cmd.run) begin
      rd_en   = ahead_ok;
      rd_addr = ahead[ROW_W-1:0];
    end
  end

  always_comb begin
    wr_en   = (cmd.host_wr && req_in_range) || cmd.run;
    wr_addr = cmd.run ? cmd.row : req_addr;
    wr_data = cmd.run ? new_row : to_row(row_bits);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_q <= vld[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prime) begin
      up  <= '0;
      mid <= eff;
    end else if (cmd.run) begin
      up  <= mid;
      mid <= dn;
    end
    if (cmd.host_rd) begin
      rd_idx_q   <= row_index;
      rd_range_q <= req_in_range;
    end
    if (cmd.out_load) begin
      out_idx  <= rd_idx_q;
      out_bits <= rd_range_q ? from_row(eff) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_free   = !out_valid || rsp.ready;
  assign rsp.valid         = out_valid;
  assign rsp.out_row_index = out_idx;
  assign rsp.out_row_bits  = out_bits;

endmodule

`default_nettype wire

// File: sv/life_automaton_generation_step_core.sv
// ----------------------------------------------------------------------------
// life_automaton_generation_step_core
// b3/s23 life grid with row write, row read and one-generation step
//
//   channel  dir  payload                          transfer
//   req      in   func, row_index, row_bits        req.valid && req.ready
//   rsp      out  out_row_index, out_row_bits      rsp.valid && rsp.ready
//
// row write and unused codes leave the core ready; a row read goes through the
// memory read register to the result register, delayed only while an earlier
// result is still held. a step primes the window, then one grid memory read per
// row, the whole row computed at once, one row written back per cycle.
// reset clears the row valid bits at once, so the grid reads as all dead.
// req.ready is low while a step or a read is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "life_automaton_generation_step_core_defines.svh"

module life_automaton_generation_step_core import lags_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  lags_in_if.sink    req,
  lags_out_if.source rsp
);

  lags_cmd_t    cmd;
  lags_status_t status;

  lags_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .valid  (req.valid),
    .func   (req.func),
    .ready  (req.ready),
    .cmd    (cmd),
    .status (status)
  );

  lags_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .row_index (req.row_index),
    .row_bits  (req.row_bits),
    .rsp       (rsp)
  );

  `LAGS_ASSERT_NEXT(a_step_holds_req, req.valid && req.ready && req.func == FUNC_STEP,
                    !req.ready, "step did not hold off requests")
  `LAGS_ASSERT_NEXT(a_step_returns_idle, cmd.run && cmd.last, req.ready,
                    "step did not return to idle after last row")
  `LAGS_ASSERT_SAME(a_no_result_overwrite, cmd.out_load, status.out_free,
                    "result register loaded while holding a result")
  `LAGS_ASSERT_SAME(a_one_action, 1'b1,
                    $onehot0({cmd.host_wr, cmd.host_rd, cmd.step_start, cmd.prime, cmd.run}),
                    "more than one datapath action at once")

endmodule

`default_nettype wire

// File: test/life_automaton_generation_step_core_checker.sv
// ----------------------------------------------------------------------------
// life_automaton_generation_step_core_checker
// watches both channels, keeps its own copy of the life grid, works out the
// row every read must return and compares each response transfer with it
// ----------------------------------------------------------------------------
module life_automaton_generation_step_core_checker import lags_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  lags_in_if        req,
  lags_out_if       rsp,
  output int        fail_count,
  output int        pending_reads
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [INDEX_W-1:0] row_index;
    logic [BITS_W-1:0]  row_bits;
  } row_read_t;

  row_t      cells [GRID_ROWS];
  row_read_t expected_rows [$];

  task automatic advance_generation();
    row_t next_cells [GRID_ROWS];
    int   live;
    int   yy;
    int   xx;
    for (int y = 0; y < GRID_ROWS; y++) begin
      for (int x = 0; x < GRID_COLS; x++) begin
        live = 0;
        for (int dy = -1; dy <= 1; dy++) begin
          for (int dx = -1; dx <= 1; dx++) begin
            yy = y + dy;
            xx = x + dx;
            if ((dy != 0 || dx != 0) && yy >= 0 && yy < GRID_ROWS && xx >= 0 && xx < GRID_COLS)
              live += int'(cells[yy][xx]);
          end
        end
        next_cells[y][x] = (live == 3) || (cells[y][x] && live == 2);
      end
    end
    cells = next_cells;
  endtask

  task automatic apply_request(input logic [FUNC_W-1:0] func, input logic [INDEX_W-1:0] idx,
                               input logic [BITS_W-1:0] bits);
    row_read_t result;
    case (func)
      FUNC_WRITE: begin
        if (int'(idx) < GRID_ROWS)
          cells[idx] = row_t'(bits);
      end
      FUNC_STEP: begin
        advance_generation();
      end
      FUNC_READ: begin
        result.row_index = idx;
        result.row_bits  = (int'(idx) < GRID_ROWS) ? BITS_W'(cells[idx]) : '0;
        expected_rows.push_back(result);
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_row_read(input logic [INDEX_W-1:0] idx, input logic [BITS_W-1:0] bits);
    row_read_t want;
    if (expected_rows.size() == 0) begin
      $display("%0t: unexpected read transfer, row %0d bits %h", $time, idx, bits);
      fail_count++;
    end else begin
      want = expected_rows.pop_front();
      if (idx !== want.row_index) begin
        $display("%0t: out_row_index expected %0d, got %0d", $time, want.row_index, idx);
        fail_count++;
      end
      if (bits !== want.row_bits) begin
        $display("%0t: out_row_bits of row %0d expected %h, got %h", $time, want.row_index,
                 want.row_bits, bits);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int y = 0; y < GRID_ROWS; y++)
        cells[y] = '0;
      expected_rows.delete();
    end else begin
      if (rsp.valid && rsp.ready)
        check_row_read(rsp.out_row_index, rsp.out_row_bits);
      if (req.valid && req.ready)
        apply_request(req.func, req.row_index, req.row_bits);
    end
    pending_reads = expected_rows.size();
  end

endmodule

// File: test/life_automaton_generation_step_core_tb.sv
// ----------------------------------------------------------------------------
// life_automaton_generation_step_core_tb
// drives row writes, generation steps, row reads and unused codes into the
// life core: a directed opening on the grid edges, then random patterns that
// are loaded, stepped and read back, under four idle and stall mixes
// ----------------------------------------------------------------------------
module life_automaton_generation_step_core_tb import lags_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_PER_PHASE = 340;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int NUM_PHASES      = 4;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending_reads;
  int   send_idle_pct = 0;
  int   rsp_stall_pct = 0;
  int   items_sent = 0;
  int   quiet_cycles = 0;

  lags_in_if  req ();
  lags_out_if rsp ();

  life_automaton_generation_step_core i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  life_automaton_generation_step_core_checker i_grid_check (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .rsp           (rsp),
    .fail_count    (fail_count),
    .pending_reads (pending_reads)
  );

  always #5 clk = ~clk;

  initial begin
    req.valid     = 1'b0;
    req.func      = FUNC_WRITE;
    req.row_index = '0;
    req.row_bits  = '0;
    rsp.ready     = 1'b0;
  end

  always @(negedge clk) begin
    rsp.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic send_item(input logic [FUNC_W-1:0] func, input logic [INDEX_W-1:0] idx,
                           input logic [BITS_W-1:0] bits);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req.valid     <= 1'b0;
      req.func      <= FUNC_W'($urandom);
      req.row_index <= INDEX_W'($urandom);
      req.row_bits  <= $urandom;
      @(negedge clk);
    end
    req.valid     <= 1'b1;
    req.func      <= func;
    req.row_index <= idx;
    req.row_bits  <= bits;
    do @(posedge clk); while (!req.ready);
    items_sent++;
  endtask

  task automatic drain_reads();
    @(negedge clk);
    req.valid <= 1'b0;
    while (pending_reads != 0)
      @(negedge clk);
  endtask

  function automatic logic [BITS_W-1:0] random_row();
    logic [2:0] shape;
    shape = 3'($urandom_range(1, 7));
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      3:       return $urandom & $urandom & $urandom;
      4:       return BITS_W'(shape) << $urandom_range(0, 29);
      5:       return BITS_W'(shape) << 29;
      default: return BITS_W'(1) << $urandom_range(0, 31);
    endcase
  endfunction

  task automatic send_step();
    send_item(FUNC_STEP, INDEX_W'($urandom), $urandom);
  endtask

  task automatic send_read(input logic [INDEX_W-1:0] idx);
    send_item(FUNC_READ, idx, $urandom);
  endtask

  // load a small pattern, run it a few generations and read around it
  task automatic pattern_episode();
    int top_row;
    int n_rows;
    int n_steps;
    int n_reads;
    top_row = $urandom_range(0, 31);
    n_rows  = $urandom_range(1, 6);
    for (int i = 0; i < n_rows; i++)
      send_item(FUNC_WRITE, INDEX_W'(top_row + i), random_row());
    if ($urandom_range(0, 3) == 0)
      send_read(INDEX_W'(top_row));
    n_steps = $urandom_range(1, 4);
    for (int s = 0; s < n_steps; s++) begin
      send_step();
      n_reads = $urandom_range(1, 4);
      for (int r = 0; r < n_reads; r++) begin
        if ($urandom_range(0, 3) != 0)
          send_read(INDEX_W'(top_row + $urandom_range(0, n_rows + 1) - 1));
        else
          send_read(INDEX_W'($urandom));
      end
    end
  endtask

  task automatic noise_episode();
    int n_items;
    n_items = $urandom_range(1, 8);
    for (int i = 0; i < n_items; i++)
      send_item(FUNC_W'($urandom), INDEX_W'($urandom), $urandom);
  endtask

  initial begin
    int phase_start;
    int send_pcts [NUM_PHASES];
    int stall_pcts [NUM_PHASES];
    send_pcts  = '{0, 65, 0, 37};
    stall_pcts = '{0, 0, 65, 37};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_read(5'd0);
    send_item(FUNC_WRITE, 5'd0, 32'hffff_ffff);
    send_item(FUNC_WRITE, 5'd31, 32'hffff_ffff);
    send_item(FUNC_WRITE, 5'd15, 32'h8000_0001);
    send_item(FUNC_WRITE, 5'd16, 32'h8000_0001);
    send_item(FUNC_WRITE, 5'd17, 32'h8000_0001);
    send_item(FUNC_UNUSED, 5'd31, 32'haaaa_aaaa);
    send_read(5'd31);
    send_read(5'd15);
    send_step();
    send_read(5'd0);
    send_read(5'd1);
    send_read(5'd16);
    send_read(5'd30);
    send_read(5'd31);
    send_step();
    send_read(5'd0);
    send_read(5'd16);
    send_item(FUNC_WRITE, 5'd0, 32'h0000_0000);
    send_read(5'd0);
    send_item(FUNC_WRITE, 5'd7, 32'h5555_5555);
    send_read(5'd7);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_reads();
      send_idle_pct = send_pcts[p];
      rsp_stall_pct = stall_pcts[p];
      phase_start   = items_sent;
      while (items_sent - phase_start < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) < 7)
          pattern_episode();
        else
          noise_episode();
      end
    end

    drain_reads();
    repeat (40) @(negedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
